/* hdl/frequency_boost_controller_unit_defines.svh */
// Assertion macros for the frequency boost controller checker.
// No dependencies; included by the checker file only.
`ifndef FREQUENCY_BOOST_CONTROLLER_UNIT_DEFINES_SVH
`define FREQUENCY_BOOST_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FBC_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FBC_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/fbc_pkg.sv */
// Shared types and constants of the frequency boost controller.
// No dependencies; imported by every module of the block.
package fbc_pkg;

   localparam int DUR_BITS       = 16;
   localparam int FREQ_BITS      = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_INPUT      = 3'd1,
      OP_MAX_BOOST  = 3'd2,
      OP_SCREEN_ON  = 3'd3,
      OP_SCREEN_OFF = 3'd4,
      OP_QUERY      = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_INPUT,
      CMD_MAX,
      CMD_WAKE,
      CMD_SLEEP,
      CMD_QUERY
   } cmd_kind_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_BOOST = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAKE_BOOST  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_A     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_B     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING_A   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING_B   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWEST_A    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWEST_B    = 3'd7;

   typedef struct packed {
      logic [2:0]          opcode;
      logic                domain;
      logic [DUR_BITS-1:0] duration_ticks;
      logic [DUR_BITS-1:0] window_ticks;
   } req_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0] floor_freq_a;
      logic                 max_flag_a;
      logic [FREQ_BITS-1:0] floor_freq_b;
      logic                 max_flag_b;
      logic                 recent_input;
   } rsp_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      cmd_kind_type        kind;
      logic                domain;
      logic [DUR_BITS-1:0] len;
      logic [DUR_BITS-1:0] window;
   } cmd_type;

   typedef struct packed {
      logic [DUR_BITS-1:0]  input_len;
      logic [DUR_BITS-1:0]  wake_boost;
      logic [FREQ_BITS-1:0] boost_a;
      logic [FREQ_BITS-1:0] boost_b;
      logic [FREQ_BITS-1:0] ceiling_a;
      logic [FREQ_BITS-1:0] ceiling_b;
      logic [FREQ_BITS-1:0] lowest_a;
      logic [FREQ_BITS-1:0] lowest_b;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      input_len:   16'd100,
      wake_boost:  16'd1000,
      boost_a:     '0,
      boost_b:     '0,
      ceiling_a:   '1,
      ceiling_b:   '1,
      lowest_a:    '0,
      lowest_b:    '0
   };

   function automatic logic [FREQ_BITS-1:0] lower_freq(input logic [FREQ_BITS-1:0] a,
                                                      input logic [FREQ_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

/* hdl/fbc_front.sv */
// Front end: takes items from the request channel and classifies them.
// Depends on fbc_pkg; feeds fbc_queue.
module fbc_front
   import fbc_pkg::*;
#(
   parameter int NUM_DOMAINS = 2
) (
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    push,
   output cmd_type push_cmd
);

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_cmd.domain = req_data.domain;
      push_cmd.len    = req_data.duration_ticks;
      push_cmd.window = req_data.window_ticks;
      unique case (opcode_type'(req_data.opcode))
         OP_TICK:       push_cmd.kind = CMD_TICK;
         OP_INPUT:      push_cmd.kind = CMD_INPUT;
         // a boost aimed at a missing domain does nothing
         OP_MAX_BOOST:  push_cmd.kind = (int'(req_data.domain) < NUM_DOMAINS) ?
                                        CMD_MAX : CMD_QUERY;
         OP_SCREEN_ON:  push_cmd.kind = CMD_WAKE;
         OP_SCREEN_OFF: push_cmd.kind = CMD_SLEEP;
         OP_QUERY:      push_cmd.kind = CMD_QUERY;
         default:       push_cmd.kind = CMD_QUERY;
      endcase
   end

endmodule

/* hdl/fbc_queue.sv */
// Short queue of classified items between front and back end.
// Depends on fbc_pkg.
module fbc_queue
   import fbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head_cmd
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff,  count_in;

   function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/fbc_back.sv */
// Back end: settings registers, per-domain boost state, result register.
// Depends on fbc_pkg; drains fbc_queue.
module fbc_back
   import fbc_pkg::*;
#(
   parameter int NUM_DOMAINS = 2,
   parameter int TIME_BITS   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      cmd_valid,
   input  cmd_type                   cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data
);

   cfg_type cfg_ff, cfg_in;

   logic [TIME_BITS-1:0]   now_ff,  now_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;
   logic [NUM_DOMAINS-1:0] off_ff,  off_in;
   logic [NUM_DOMAINS-1:0] ib_ff,   ib_in;
   logic [NUM_DOMAINS-1:0] mb_ff,   mb_in;
   logic [TIME_BITS-1:0]   idl_ff [NUM_DOMAINS];
   logic [TIME_BITS-1:0]   idl_in [NUM_DOMAINS];
   logic [TIME_BITS-1:0]   mdl_ff [NUM_DOMAINS];
   logic [TIME_BITS-1:0]   mdl_in [NUM_DOMAINS];

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff,  rsp_data_in;

   logic [DUR_BITS-1:0]    boost_len;
   logic [TIME_BITS-1:0]   new_deadline;
   logic [NUM_DOMAINS-1:0] longer_running;
   logic [NUM_DOMAINS+1:0] off_ext, ib_ext, mb_ext;

   // a precedes b: top bit of the wrapped difference
   function automatic logic precedes(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] diff;
      diff = a - b;
      return diff[TIME_BITS-1];
   endfunction

   // settings
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_INPUT_BOOST: cfg_in.input_len   = csr_wdata[DUR_BITS-1:0];
            CSR_WAKE_BOOST:  cfg_in.wake_boost  = csr_wdata[DUR_BITS-1:0];
            CSR_BOOST_A:     cfg_in.boost_a     = csr_wdata[FREQ_BITS-1:0];
            CSR_BOOST_B:     cfg_in.boost_b     = csr_wdata[FREQ_BITS-1:0];
            CSR_CEILING_A:   cfg_in.ceiling_a   = csr_wdata[FREQ_BITS-1:0];
            CSR_CEILING_B:   cfg_in.ceiling_b   = csr_wdata[FREQ_BITS-1:0];
            CSR_LOWEST_A:    cfg_in.lowest_a    = csr_wdata[FREQ_BITS-1:0];
            CSR_LOWEST_B:    cfg_in.lowest_b    = csr_wdata[FREQ_BITS-1:0];
         endcase
      end
   end

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   // max boost candidate, shared by request and wake
   always_comb begin
      boost_len    = (cmd.kind == CMD_WAKE) ? cfg_ff.wake_boost : cmd.len;
      new_deadline = now_ff + TIME_BITS'(boost_len);
      for (int d = 0; d < NUM_DOMAINS; d++) begin
         longer_running[d] = mb_ff[d] && precedes(new_deadline, mdl_ff[d]);
      end
   end

   // event, then expiry against the updated time
   always_comb begin
      now_in  = now_ff;
      last_in = last_ff;
      off_in  = off_ff;
      ib_in   = ib_ff;
      mb_in   = mb_ff;
      idl_in  = idl_ff;
      mdl_in  = mdl_ff;
      unique case (cmd.kind)
         CMD_TICK: now_in = now_ff + TIME_BITS'(1);
         CMD_INPUT: begin
            for (int d = 0; d < NUM_DOMAINS; d++) begin
               if (!off_ff[d]) begin
                  ib_in[d]  = 1'b1;
                  idl_in[d] = now_ff + TIME_BITS'(cfg_ff.input_len);
               end
            end
            last_in = now_ff;
         end
         CMD_MAX: begin
            for (int d = 0; d < NUM_DOMAINS; d++) begin
               if (int'(cmd.domain) == d && !off_ff[d] && !longer_running[d]) begin
                  mb_in[d]  = 1'b1;
                  mdl_in[d] = new_deadline;
               end
            end
         end
         CMD_WAKE: begin
            off_in = '0;
            for (int d = 0; d < NUM_DOMAINS; d++) begin
               if (!longer_running[d]) begin
                  mb_in[d]  = 1'b1;
                  mdl_in[d] = new_deadline;
               end
            end
         end
         CMD_SLEEP: off_in = '1;
         CMD_QUERY: ;
         default: ;
      endcase
      for (int d = 0; d < NUM_DOMAINS; d++) begin
         ib_in[d] = ib_in[d] && precedes(now_in, idl_in[d]);
         mb_in[d] = mb_in[d] && precedes(now_in, mdl_in[d]);
      end
   end

   // result from the updated state; missing domains read as zero
   always_comb begin
      off_ext = {2'b00, off_in};
      ib_ext  = {2'b00, ib_in};
      mb_ext  = {2'b00, mb_in};
      rsp_data_in.floor_freq_a = (off_ext[0] || !ib_ext[0]) ? cfg_ff.lowest_a :
                                 lower_freq(cfg_ff.boost_a, cfg_ff.ceiling_a);
      rsp_data_in.max_flag_a   = !off_ext[0] && mb_ext[0];
      if (NUM_DOMAINS > 1) begin
         rsp_data_in.floor_freq_b = (off_ext[1] || !ib_ext[1]) ? cfg_ff.lowest_b :
                                    lower_freq(cfg_ff.boost_b, cfg_ff.ceiling_b);
         rsp_data_in.max_flag_b   = !off_ext[1] && mb_ext[1];
      end else begin
         rsp_data_in.floor_freq_b = '0;
         rsp_data_in.max_flag_b   = 1'b0;
      end
      rsp_data_in.recent_input = precedes(now_in, last_in + TIME_BITS'(cmd.window));
   end

   always_comb begin
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         now_ff       <= '0;
         last_ff      <= '0;
         off_ff       <= '0;
         ib_ff        <= '0;
         mb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_pop) begin
            now_ff  <= now_in;
            last_ff <= last_in;
            off_ff  <= off_in;
            ib_ff   <= ib_in;
            mb_ff   <= mb_in;
         end
      end
   end

   // deadlines only matter while their flag is set
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         idl_ff      <= idl_in;
         mdl_ff      <= mdl_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/frequency_boost_controller_unit.sv */
// Top level of the frequency boost controller.
// Depends on fbc_pkg, fbc_front, fbc_queue and fbc_back.
//
//   port group   role          handshake         payload
//   req_*        items in      valid / stall     req_type (opcode, domain, ticks)
//   rsp_*        results out   valid / stall     rsp_type (floors, flags, recent)
//   csr_*        settings      write enable      index 0..7, 32-bit data
//
// One item per cycle sustained while rsp_stall stays low; each taken item passes
// through a queue slot, then the result register, before its result appears.
// The front takes an item whenever the two-entry queue has room, so it keeps
// accepting while a result waits under rsp_stall; it stalls once both fill.
// Synchronous active-high reset clears time, flags and queue and restores default settings.
module frequency_boost_controller_unit
   import fbc_pkg::*;
#(
   parameter int NUM_DOMAINS = 2,   // 1..8
   parameter int TIME_BITS   = 32   // 16..64, tick counter width
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_head_cmd;

   // classify: opcodes 5..7 and out-of-range boosts become plain queries
   fbc_front #(
      .NUM_DOMAINS (NUM_DOMAINS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (q_push),
      .push_cmd  (q_push_cmd)
   );

   // decouples request stalls from result stalls
   fbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (q_head_cmd)
   );

   // applies the event, expires boosts, registers the result
   fbc_back #(
      .NUM_DOMAINS (NUM_DOMAINS),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (q_valid),
      .cmd       (q_head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/fbc_checker.sv */
// Port-level checks of the frequency boost controller, bound to the top level.
// Depends on fbc_pkg and frequency_boost_controller_unit_defines.svh.
`include "frequency_boost_controller_unit_defines.svh"

module fbc_checker
   import fbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 2) + 1;

   logic [CNT_BITS-1:0] open_ff, open_in;
   logic                in_take;
   logic                out_take;

   // items taken whose result has not yet been delivered
   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;
   assign open_in  = open_ff + CNT_BITS'(in_take) - CNT_BITS'(out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `FBC_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `FBC_CHECK_NOW(a_open_bound, 1'b1, open_ff <= CNT_BITS'(QUEUE_DEPTH + 1), "too many items in flight")
   `FBC_CHECK_NOW(a_rsp_has_item, rsp_valid, open_ff != '0, "result without an item")
   `FBC_CHECK_NOW(a_empty_takes, open_ff == '0, !req_stall, "stall while empty")

endmodule

bind frequency_boost_controller_unit fbc_checker u_fbc_checker (.*);

/* test/tb_frequency_boost_controller_unit.sv */
`timescale 1ns / 100ps
// Self-checking bench for frequency_boost_controller_unit: directed and random items.
// A scoreboard class predicts each result and compares it. Needs fbc_pkg and the RTL only.
module tb_frequency_boost_controller_unit;
   import fbc_pkg::*;

   // Opcodes beyond the enum; the block must treat them as a plain query
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int IDLE_LIMIT  = 2000;   // cycles with no item moved on either side
   localparam int PHASE_ITEMS = 460;

   // ------------------------------------------------------------------
   // Boost-state tracker: mirrors the controller and owes one result per item
   // ------------------------------------------------------------------
   class boost_scoreboard;
      cfg_type     cfg;
      logic [31:0] now_t;
      logic [31:0] last_input_t;
      bit          scr_off[2];
      bit          in_boost[2];
      bit          max_on[2];
      logic [31:0] in_deadline[2];
      logic [31:0] max_deadline[2];
      rsp_type     owed[$];
      int          errors;

      function new();
         cfg          = CFG_RESET;
         now_t        = '0;
         last_input_t = '0;
         errors       = 0;
         for (int d = 0; d < 2; d++) begin
            scr_off[d]      = 1'b0;
            in_boost[d]     = 1'b0;
            max_on[d]       = 1'b0;
            in_deadline[d]  = '0;
            max_deadline[d] = '0;
         end
      endfunction

      // wrapping time order: a lies before b when a - b is negative
      function bit earlier(logic [31:0] a, logic [31:0] b);
         logic [31:0] diff;
         diff = a - b;
         return diff[31];
      endfunction

      // a running boost that ends later is kept; an equal deadline is taken
      function void arm_max(int d, logic [15:0] len);
         logic [31:0] ends_at;
         ends_at = now_t + 32'(len);
         if (scr_off[d]) return;
         if (max_on[d] && earlier(ends_at, max_deadline[d])) return;
         max_deadline[d] = ends_at;
         max_on[d]       = 1'b1;
      endfunction

      function logic [31:0] floor_of(int d);
         logic [31:0] boost, cap, low;
         boost = d ? cfg.boost_b   : cfg.boost_a;
         cap   = d ? cfg.ceiling_b : cfg.ceiling_a;
         low   = d ? cfg.lowest_b  : cfg.lowest_a;
         if (scr_off[d] || !in_boost[d]) return low;
         return (boost < cap) ? boost : cap;
      endfunction

      function void note_item(req_type item);
         rsp_type r;
         case (item.opcode)
            OP_TICK: now_t = now_t + 32'd1;
            OP_INPUT: begin
               for (int d = 0; d < 2; d++) begin
                  if (!scr_off[d]) begin
                     in_boost[d]    = 1'b1;
                     in_deadline[d] = now_t + 32'(cfg.input_len);
                  end
               end
               // recorded even with the screen off
               last_input_t = now_t;
            end
            OP_MAX_BOOST: arm_max(int'(item.domain), item.duration_ticks);
            OP_SCREEN_ON: begin
               for (int d = 0; d < 2; d++) begin
                  scr_off[d] = 1'b0;
                  arm_max(d, cfg.wake_boost);
               end
            end
            OP_SCREEN_OFF: for (int d = 0; d < 2; d++) scr_off[d] = 1'b1;
            default: ;
         endcase
         // expiry after the event, so a zero-length boost ends at once
         for (int d = 0; d < 2; d++) begin
            if (in_boost[d] && !earlier(now_t, in_deadline[d])) in_boost[d] = 1'b0;
            if (max_on[d] && !earlier(now_t, max_deadline[d])) max_on[d] = 1'b0;
         end
         r.floor_freq_a = floor_of(0);
         r.max_flag_a   = max_on[0] && !scr_off[0];
         r.floor_freq_b = floor_of(1);
         r.max_flag_b   = max_on[1] && !scr_off[1];
         r.recent_input = earlier(now_t, last_input_t + 32'(item.window_ticks));
         owed.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none, actual %p",
                     $time, got);
            return;
         end
         want = owed.pop_front();
         compare("floor_freq_a", want.floor_freq_a, got.floor_freq_a);
         compare("max_flag_a",   32'(want.max_flag_a),   32'(got.max_flag_a));
         compare("floor_freq_b", want.floor_freq_b, got.floor_freq_b);
         compare("max_flag_b",   32'(want.max_flag_b),   32'(got.max_flag_b));
         compare("recent_input", 32'(want.recent_input), 32'(got.recent_input));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Block under test; every input starts at a known value
   // ------------------------------------------------------------------
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   boost_scoreboard sb;
   bit              calm = 1'b0;    // set: neither side idles
   int              idle_cycles = 0;

   frequency_boost_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Result side back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 37);
   end

   // Monitor: results are checked before the same edge's item is noted, so
   // a result can never be matched against an item taken on that very edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_item(req_data);
      end
   end

   // Watchdog: a hang on either side shows up as a long run with no transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("frequency_boost_controller_unit regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Present one item and hold it until taken; valid is left high so a
   // back-to-back item never lowers and raises it on one edge. Idle gaps come
   // at random before an item, with the same odds at each step, unless calm is set.
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      while (!calm && $urandom_range(99) < 37) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // bounded by the watchdog
   task automatic wait_drained();
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Only called with nothing in flight. Junk in the upper half of the
   // tick registers checks that only 16 bits are kept.
   task automatic program_regs(input cfg_type c);
      write_reg(CSR_INPUT_BOOST, {16'($urandom), c.input_len});
      write_reg(CSR_WAKE_BOOST,  {16'($urandom), c.wake_boost});
      write_reg(CSR_BOOST_A,     c.boost_a);
      write_reg(CSR_BOOST_B,     c.boost_b);
      write_reg(CSR_CEILING_A,   c.ceiling_a);
      write_reg(CSR_CEILING_B,   c.ceiling_b);
      write_reg(CSR_LOWEST_A,    c.lowest_a);
      write_reg(CSR_LOWEST_B,    c.lowest_b);
      @(negedge clock);
      csr_write <= 1'b0;
      sb.cfg = c;
   endtask

   function automatic req_type make_item(logic [2:0] op, logic dom,
                                         logic [15:0] dur, logic [15:0] win);
      req_type r;
      r.opcode         = op;
      r.domain         = dom;
      r.duration_ticks = dur;
      r.window_ticks   = win;
      return r;
   endfunction

   // short lengths keep boosts expiring within a phase; a few span the range
   function automatic logic [15:0] pick_ticks();
      int pick;
      pick = $urandom_range(9);
      if (pick < 7) return 16'($urandom_range(0, 40));
      if (pick < 9) return 16'($urandom_range(0, 600));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Ticks dominate so that boosts run out; screen changes are kept rare
   // enough that the screen is on for a good part of the time
   function automatic req_type random_item();
      int          pick;
      logic [2:0]  op;
      pick = $urandom_range(99);
      if (pick < 38)      op = OP_TICK;
      else if (pick < 52) op = OP_INPUT;
      else if (pick < 68) op = OP_MAX_BOOST;
      else if (pick < 73) op = OP_SCREEN_ON;
      else if (pick < 77) op = OP_SCREEN_OFF;
      else if (pick < 92) op = OP_QUERY;
      else                op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      return make_item(op, 1'($urandom), pick_ticks(), pick_ticks());
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.input_len   = 16'($urandom_range(0, 40));
      c.wake_boost  = 16'($urandom_range(0, 80));
      c.boost_a     = $urandom;
      c.boost_b     = $urandom;
      c.ceiling_a   = ($urandom_range(3) == 0) ? c.boost_a : $urandom;
      c.ceiling_b   = ($urandom_range(3) == 0) ? c.boost_b : $urandom;
      c.lowest_a    = $urandom;
      c.lowest_b    = $urandom;
      return c;
   endfunction

   // Phases: random, zero lengths with extreme floors, full lengths, random
   function automatic cfg_type phase_cfg(int phase);
      case (phase)
         1: return '{input_len: 16'd0, wake_boost: 16'd0,
                     boost_a: '1, boost_b: '1, ceiling_a: '1, ceiling_b: '0,
                     lowest_a: '0, lowest_b: '1};
         2: return '{input_len: 16'hFFFF, wake_boost: 16'hFFFF,
                     boost_a: 32'hFFFF_FFFE, boost_b: 32'd1,
                     ceiling_a: '1, ceiling_b: 32'd1,
                     lowest_a: '1, lowest_b: '0};
         default: return random_cfg();
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Distinct floors per domain; domain one's boost is capped by its ceiling
      program_regs('{input_len: 16'd5, wake_boost: 16'd8,
                     boost_a: 32'h8000_0000, boost_b: 32'h0000_7777,
                     ceiling_a: '1, ceiling_b: 32'h0000_1000,
                     lowest_a: 32'h11, lowest_b: 32'h22});

      // Directed: field extremes, every opcode and the corner cases
      send_item(make_item(OP_QUERY, 1'b1, 16'hFFFF, 16'hFFFF));   // widest window
      send_item(make_item(OP_QUERY, 1'b0, 16'h0000, 16'h0000));   // empty window
      send_item(make_item(OP_INPUT, 1'b0, 16'd0, 16'd3));
      send_item(make_item(OP_TICK, 1'b0, 16'd0, 16'd3));
      send_item(make_item(OP_MAX_BOOST, 1'b0, 16'd0, 16'd3));     // ends in same item
      send_item(make_item(OP_MAX_BOOST, 1'b1, 16'hFFFF, 16'd3));
      send_item(make_item(OP_MAX_BOOST, 1'b1, 16'd3, 16'd3));     // shorter: kept long
      send_item(make_item(OP_MAX_BOOST, 1'b0, 16'd10, 16'd3));
      send_item(make_item(OP_TICK, 1'b0, 16'd0, 16'd3));
      send_item(make_item(OP_MAX_BOOST, 1'b0, 16'd9, 16'd3));     // equal deadline
      send_item(make_item(OP_SCREEN_OFF, 1'b0, 16'd0, 16'd3));
      send_item(make_item(OP_INPUT, 1'b0, 16'd0, 16'd3));         // ignored, time kept
      send_item(make_item(OP_MAX_BOOST, 1'b0, 16'd50, 16'd3));    // ignored while off
      send_item(make_item(OP_TICK, 1'b1, 16'd0, 16'd3));
      send_item(make_item(OP_SCREEN_ON, 1'b0, 16'd0, 16'd3));     // wake boost
      send_item(make_item(OP_SPARE_LO, 1'b1, 16'hFFFF, 16'd2));
      send_item(make_item(OP_SPARE_HI, 1'b1, 16'hFFFF, 16'd2));
      repeat (5) send_item(make_item(OP_TICK, 1'b0, 16'd0, 16'd4)); // input boost runs out
      send_item(make_item(OP_INPUT, 1'b1, 16'd0, 16'd1));
      send_item(make_item(OP_QUERY, 1'b0, 16'd0, 16'hFFFF));
      send_item(make_item(OP_TICK, 1'b0, 16'd0, 16'd1));

      for (int phase = 0; phase < 4; phase++) begin
         // settings change only with the block idle
         sender_idle();
         wait_drained();
         repeat (2) @(posedge clock);
         program_regs(phase_cfg(phase));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            calm = (phase == 1) && (n < 250);
            // now and then hold off until every result is back
            if ($urandom_range(99) == 0) begin
               sender_idle();
               wait_drained();
            end
            send_item(random_item());
         end
      end
      calm = 1'b0;

      sender_idle();
      wait_drained();
      repeat (6) @(posedge clock);   // catch any stray result
      if (sb.errors == 0) begin
         $display("frequency_boost_controller_unit regression: pass");
      end else begin
         $display("frequency_boost_controller_unit regression: fail");
      end
      $finish;
   end

endmodule
